>>> hw/rtl/cfd_pkg.sv
package cfd_pkg;

    localparam int MAX_PAYLOAD    = 256;
    localparam int PAY_AW         = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int MEM_AW         = PAY_AW + 1;
    localparam int MEM_DEPTH      = 2 ** MEM_AW;

    localparam int CNT_W          = 16;
    localparam int LEN_W          = 9;
    localparam int CFG_IW         = 2;
    localparam int CFG_DW         = 9;
    localparam int IN_DW          = 16;
    localparam int OUT_DW         = 24;

    localparam logic [CNT_W-1:0] COUNT_MAX      = 16'hFFFF;
    localparam logic [CNT_W:0]   FRAME_OVERHEAD = 17'd6;
    localparam logic [CNT_W:0]   HEADER_BYTES   = 17'd4;
    localparam logic [7:0]       CRC_POLY       = 8'h07;
    localparam logic [7:0]       CRC_INIT       = 8'h00;
    localparam logic [7:0]       CRC_MSB        = 8'h80;

    localparam logic [CFG_IW-1:0] CFG_SYNC_FIRST  = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_SYNC_SECOND = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_TRAILER     = 2'd2;
    localparam logic [CFG_IW-1:0] CFG_EXP_LENGTH  = 2'd3;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_HEADER  = 3'd1,
        ST_LENGTH  = 3'd2,
        ST_CRC     = 3'd3,
        ST_TRAILER = 3'd4
    } t_status;

    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if ((c & CRC_MSB) != 8'h00) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

>>> hw/rtl/crc8_checked_frame_deframer.sv
// Frame deframer with sync, length and CRC-8 checks.
// Input stream: one request per beat. tuser = 0 pushes the byte in tdata[7:0],
// with tlast on the final byte of a frame; tuser = 1 reads the committed
// payload byte at index tdata[15:8]. A frame is two sync bytes, a big-endian
// 16-bit length, the payload, a CRC-8 (poly 0x07) over length and payload,
// and an end byte. Payload bytes land in the shadow half of a two-bank
// payload RAM; a clean frame swaps the banks and updates the stored length.
// Output stream: one beat per read and per last byte; tuser = 1 marks a read
// reply. Pushes without tlast give no beat.
// Throughput: one request per cycle while the output is not stalled. A result
// passes the RAM read stage and then the output register; the read stage is
// the registered read port of the payload RAM.
// Configuration writes (index 0..3: sync_first, sync_second, trailer, expected length)
// are always ready; the user must make them only while the block is idle (not enforced).
// Reset: synchronous, active low; restores register defaults, clears the
// frame state and empties the pipeline. RAM contents are not cleared.
// Output stall: two result stages buffer the pipeline; input ready drops only
// when both are full and the receiver holds tready low.
module crc8_checked_frame_deframer (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // configuration write channel
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [cfd_pkg::CFG_IW-1:0] i_cfg_index,
    input  logic [cfd_pkg::CFG_DW-1:0] i_cfg_data,
    // input stream
    input  logic                       i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    input  logic [cfd_pkg::IN_DW-1:0]  i_s_axis_tdata,  // [7:0] frame_byte, [15:8] read_index
    input  logic                       i_s_axis_tlast,
    input  logic                       i_s_axis_tuser,  // [0] opcode
    // output stream
    output logic                       o_m_axis_tvalid,
    input  logic                       i_m_axis_tready,
    output logic [cfd_pkg::OUT_DW-1:0] o_m_axis_tdata,  // [2:0] frame_status,
                                                        // [11:3] stored_length,
                                                        // [19:12] read_byte, [23:20] zero
    output logic                       o_m_axis_tuser   // [0] is_read_reply
);
    import cfd_pkg::*;

    // configuration
    logic [7:0]       r_sync_first;
    logic [7:0]       r_sync_second;
    logic [7:0]       r_trailer;
    logic [LEN_W-1:0] r_exp_len;

    // frame state
    logic [CNT_W-1:0] r_count,    n_count;
    logic             r_hdr_good, n_hdr_good;
    logic [15:0]      r_dlen,     n_dlen;
    logic [7:0]       r_crc,      n_crc;
    logic [7:0]       r_cap_crc,  n_cap_crc;
    logic [7:0]       r_cap_tr,   n_cap_tr;
    logic             r_bank;
    logic [LEN_W-1:0] r_com_len,  n_com_len;

    // payload RAM
    logic [7:0]        r_mem [MEM_DEPTH];
    logic [7:0]        r_rd_data;
    logic              mem_we;
    logic [MEM_AW-1:0] mem_wa;
    logic [MEM_AW-1:0] mem_ra;
    logic [CNT_W-1:0]  off;
    logic [CNT_W-1:0]  ridx_ext;

    // pipeline
    logic             r_s1_valid;
    logic             r_s1_isrd;
    logic             r_s1_rd_ok;
    t_status          r_s1_status;
    logic [LEN_W-1:0] r_s1_len;
    logic             r_out_valid;
    logic             r_out_isrd;
    t_status          r_out_status;
    logic [LEN_W-1:0] r_out_len;
    logic [7:0]       r_out_byte;

    logic             s1_move;
    logic             s_acc;
    logic             push_acc;
    logic             rd_acc;
    logic             last_acc;
    logic             rd_ok;
    logic [7:0]       in_byte;
    logic [7:0]       in_ridx;
    logic [CNT_W:0]   pos_ext;
    logic [CNT_W:0]   crc_pos;
    logic             sat;
    t_status          status;

    assign in_byte  = i_s_axis_tdata[7:0];
    assign in_ridx  = i_s_axis_tdata[15:8];

    assign s1_move         = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = !r_s1_valid || s1_move;
    assign s_acc           = i_s_axis_tvalid && o_s_axis_tready;
    assign push_acc        = s_acc && (i_s_axis_tuser == OP_PUSH);
    assign rd_acc          = s_acc && (i_s_axis_tuser == OP_READ);
    assign last_acc        = push_acc && i_s_axis_tlast;
    assign o_cfg_ready     = 1'b1;

    // push datapath
    always_comb begin
        n_count    = r_count;
        n_hdr_good = r_hdr_good;
        n_dlen     = r_dlen;
        n_crc      = r_crc;
        n_cap_crc  = r_cap_crc;
        n_cap_tr   = r_cap_tr;
        mem_we     = 1'b0;
        pos_ext    = {1'b0, r_count};
        crc_pos    = {1'b0, r_dlen} + HEADER_BYTES;
        off        = r_count - CNT_W'(4);
        sat        = (r_count == COUNT_MAX);
        if (!sat) begin
            n_count = r_count + CNT_W'(1);
            if (r_count == CNT_W'(0)) begin
                if (in_byte != r_sync_first) begin
                    n_hdr_good = 1'b0;
                end
            end else if (r_count == CNT_W'(1)) begin
                if (in_byte != r_sync_second) begin
                    n_hdr_good = 1'b0;
                end
            end else if (r_count == CNT_W'(2)) begin
                n_dlen = {in_byte, 8'h00};
                n_crc  = crc8_byte(r_crc, in_byte);
            end else if (r_count == CNT_W'(3)) begin
                n_dlen = {r_dlen[15:8], r_dlen[7:0] | in_byte};
                n_crc  = crc8_byte(r_crc, in_byte);
            end else if (pos_ext < crc_pos) begin
                n_crc  = crc8_byte(r_crc, in_byte);
                mem_we = push_acc && (off < CNT_W'(MAX_PAYLOAD));
            end else if (pos_ext == crc_pos) begin
                n_cap_crc = in_byte;
            end else if (pos_ext == crc_pos + 17'd1) begin
                n_cap_tr = in_byte;
            end
        end
        mem_wa = {~r_bank, off[PAY_AW-1:0]};
    end

    // frame checks on the updated state
    always_comb begin
        if ((n_count < CNT_W'(FRAME_OVERHEAD)) || !n_hdr_good) begin
            status = ST_HEADER;
        end else if ((n_dlen != 16'(r_exp_len)) || (n_dlen > 16'(MAX_PAYLOAD))
                     || ({1'b0, n_count} != {1'b0, n_dlen} + FRAME_OVERHEAD)) begin
            status = ST_LENGTH;
        end else if (n_crc != n_cap_crc) begin
            status = ST_CRC;
        end else if (n_cap_tr != r_trailer) begin
            status = ST_TRAILER;
        end else begin
            status = ST_OK;
        end
        n_com_len = (status == ST_OK) ? n_dlen[LEN_W-1:0] : r_com_len;
    end

    // read address
    assign ridx_ext = CNT_W'(in_ridx);
    assign rd_ok    = (9'(in_ridx) < r_com_len) && (ridx_ext < CNT_W'(MAX_PAYLOAD));
    assign mem_ra   = {r_bank, ridx_ext[PAY_AW-1:0]};

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= in_byte;
        end
        if (rd_acc) begin
            r_rd_data <= r_mem[mem_ra];
        end
    end

    // configuration and frame state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_first  <= 8'd170;
            r_sync_second <= 8'd85;
            r_trailer     <= 8'd13;
            r_exp_len     <= '0;
            r_count       <= '0;
            r_hdr_good    <= 1'b1;
            r_dlen        <= '0;
            r_crc         <= CRC_INIT;
            r_cap_crc     <= '0;
            r_cap_tr      <= '0;
            r_bank        <= 1'b0;
            r_com_len     <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_SYNC_FIRST:  r_sync_first  <= i_cfg_data[7:0];
                    CFG_SYNC_SECOND: r_sync_second <= i_cfg_data[7:0];
                    CFG_TRAILER:     r_trailer     <= i_cfg_data[7:0];
                    CFG_EXP_LENGTH:  r_exp_len     <= i_cfg_data[LEN_W-1:0];
                    default: ;
                endcase
            end
            if (last_acc) begin
                r_count    <= '0;
                r_hdr_good <= 1'b1;
                r_dlen     <= '0;
                r_crc      <= CRC_INIT;
                r_cap_crc  <= '0;
                r_cap_tr   <= '0;
                r_com_len  <= n_com_len;
                if (status == ST_OK) begin
                    r_bank <= ~r_bank;
                end
            end else if (push_acc) begin
                r_count    <= n_count;
                r_hdr_good <= n_hdr_good;
                r_dlen     <= n_dlen;
                r_crc      <= n_crc;
                r_cap_crc  <= n_cap_crc;
                r_cap_tr   <= n_cap_tr;
            end
        end
    end

    // result pipeline: RAM read stage, then output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_move) begin
                r_out_valid <= r_s1_valid;
            end
            if (o_s_axis_tready) begin
                r_s1_valid <= rd_acc || last_acc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_s1_isrd   <= rd_acc;
            r_s1_rd_ok  <= rd_ok;
            r_s1_status <= rd_acc ? ST_OK : status;
            r_s1_len    <= rd_acc ? r_com_len : n_com_len;
        end
        if (s1_move && r_s1_valid) begin
            r_out_isrd   <= r_s1_isrd;
            r_out_status <= r_s1_status;
            r_out_len    <= r_s1_len;
            r_out_byte   <= (r_s1_isrd && r_s1_rd_ok) ? r_rd_data : 8'h00;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_isrd;
    assign o_m_axis_tdata  = {4'h0, r_out_byte, r_out_len, r_out_status};

    a_status_no_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tuser) |-> (o_m_axis_tdata[19:12] == 8'h00))
        else $error("status result carries a nonzero read byte");

    a_reply_status_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser) |-> (o_m_axis_tdata[2:0] == ST_OK))
        else $error("read reply carries a frame status");

    a_bank_swap_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !last_acc |=> (r_bank == $past(r_bank)))
        else $error("bank swapped without a frame end");

    a_count_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_count == COUNT_MAX) && push_acc && !i_s_axis_tlast) |=> (r_count == COUNT_MAX))
        else $error("byte counter wrapped");

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_out_valid && !i_m_axis_tready) |-> !o_s_axis_tready)
        else $error("input accepted with both result stages full");

endmodule
